FILE: rtl/quaternion_vector_rotate_core_macros.svh
// Assertion macros used by the port-level checker of the rotate core.
`ifndef QUATERNION_VECTOR_ROTATE_CORE_MACROS_SVH
`define QUATERNION_VECTOR_ROTATE_CORE_MACROS_SVH

// Same-cycle implication.
`define QVR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qvr assertion failed");

// Next-cycle implication.
`define QVR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qvr assertion failed");

`endif

FILE: rtl/qvr_pkg.sv
// Package for the quaternion vector rotate core: the side-flag type.
`default_nettype none
package qvr_pkg;

  // Per-item flags that ride alongside the divider pipeline.
  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } qvr_side_t;

endpackage
`default_nettype wire

FILE: rtl/qvr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module qvr_div #(
  parameter int DW = 87,
  parameter int RW = 35,
  parameter int QB = 34
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] dvd,
  input  wire logic [RW-1:0] den,
  output logic      [QB-1:0] quo
);
  logic [RW-1:0] rem_r  [QB-1];
  logic [QB-1:0] quo_r  [QB];
  logic [QB-1:0] low_r  [QB-1];
  logic [RW-1:0] den_r  [QB-1];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [QB-1:0] low_in;
    logic [QB-1:0] quo_in;
    logic [RW-1:0] den_in;
    logic [RW-1:0] t;
    logic          ge;

    if (i == 0) begin : g_first
      // upper dividend bits start below the divisor by range of the result
      assign rem_in = RW'(dvd[DW-1:QB]);
      assign low_in = dvd[QB-1:0];
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_rest
      assign rem_in = rem_r[i-1];
      assign low_in = low_r[i-1];
      assign quo_in = quo_r[i-1];
      assign den_in = den_r[i-1];
    end

    assign t  = {rem_in[RW-2:0], low_in[QB-1]};
    assign ge = (t >= den_in);

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[i] <= {quo_in[QB-2:0], ge};
      end
    end

    // the last stage keeps only its quotient bit
    if (i < QB-1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= ge ? (t - den_in) : t;
          low_r[i] <= {low_in[QB-2:0], 1'b0};
          den_r[i] <= den_in;
        end
      end
    end
  end

  assign quo = quo_r[QB-1];
endmodule
`default_nettype wire

FILE: rtl/quaternion_vector_rotate_core.sv
// Top level of the quaternion vector rotate core.
// Rotates v by q: returns the vector part of q*(0,v)*conj(q)/|q|^2, rounded to nearest
// (ties away from zero) and saturated to VEC_BITS. Fully pipelined: one transaction per
// cycle in, one per cycle out, except while stalled; the pipeline is four arithmetic stages, a
// VEC_BITS+2 stage restoring divider per component, and the output register. The whole
// pipeline holds while a result waits at the output. A zero quaternion returns zeros
// with zero_quat set.
`default_nettype none
module quaternion_vector_rotate_core #(
  parameter int QUAT_BITS = 16,
  parameter int VEC_BITS  = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [QUAT_BITS-1:0] quat_w,
  input  wire logic signed [QUAT_BITS-1:0] quat_x,
  input  wire logic signed [QUAT_BITS-1:0] quat_y,
  input  wire logic signed [QUAT_BITS-1:0] quat_z,
  input  wire logic signed [VEC_BITS-1:0]  pos_x,
  input  wire logic signed [VEC_BITS-1:0]  pos_y,
  input  wire logic signed [VEC_BITS-1:0]  pos_z,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [VEC_BITS-1:0]       rot_x,
  output logic signed [VEC_BITS-1:0]       rot_y,
  output logic signed [VEC_BITS-1:0]       rot_z,
  output logic                             saturated,
  output logic                             zero_quat
);
  import qvr_pkg::*;

  localparam int QW   = QUAT_BITS;
  localparam int VW   = VEC_BITS;
  localparam int SQW  = 2*QW;
  localparam int NW   = 2*QW + 2;
  localparam int PVW  = QW + VW;
  localparam int DOTW = QW + VW + 2;
  localparam int CRW  = QW + VW + 1;
  localparam int AVW  = NW + VW;
  localparam int XDW  = QW + DOTW;
  localparam int WCW  = QW + CRW;
  localparam int NUMW = 2*QW + VW + 5;
  localparam int DW   = NUMW + 2;
  localparam int RW   = 2*QW + 3;
  localparam int QB   = VW + 2;
  localparam int L    = QB + 5;

  logic         adv;
  logic [L-1:0] vld;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], in_valid};
    end
  end

  // stage A: squares and quaternion-by-vector products
  logic signed [SQW-1:0] ww, xx, yy, zz;
  logic signed [PVW-1:0] pxv, pyv, pzv, pyz, pzy, pzx, pxz, pxy, pyx;
  logic signed [QW-1:0]  wa, xa, ya, za;
  logic signed [VW-1:0]  vxa, vya, vza;

  always_ff @(posedge clk) begin
    if (adv) begin
      ww  <= quat_w * quat_w;
      xx  <= quat_x * quat_x;
      yy  <= quat_y * quat_y;
      zz  <= quat_z * quat_z;
      pxv <= quat_x * pos_x;
      pyv <= quat_y * pos_y;
      pzv <= quat_z * pos_z;
      pyz <= quat_y * pos_z;
      pzy <= quat_z * pos_y;
      pzx <= quat_z * pos_x;
      pxz <= quat_x * pos_z;
      pxy <= quat_x * pos_y;
      pyx <= quat_y * pos_x;
      wa  <= quat_w;
      xa  <= quat_x;
      ya  <= quat_y;
      za  <= quat_z;
      vxa <= pos_x;
      vya <= pos_y;
      vza <= pos_z;
    end
  end

  // stage B: norm, w^2-u.u, dot and cross products
  logic signed [NW-1:0]   nb, ab;
  logic signed [DOTW-1:0] db;
  logic signed [CRW-1:0]  cxb, cyb, czb;
  logic signed [QW-1:0]   wb, xb, yb, zb;
  logic signed [VW-1:0]   vxb, vyb, vzb;

  always_ff @(posedge clk) begin
    if (adv) begin
      nb  <= NW'(ww) + NW'(xx) + NW'(yy) + NW'(zz);
      ab  <= NW'(ww) - (NW'(xx) + NW'(yy) + NW'(zz));
      db  <= DOTW'(pxv) + DOTW'(pyv) + DOTW'(pzv);
      cxb <= CRW'(pyz) - CRW'(pzy);
      cyb <= CRW'(pzx) - CRW'(pxz);
      czb <= CRW'(pxy) - CRW'(pyx);
      wb  <= wa;
      xb  <= xa;
      yb  <= ya;
      zb  <= za;
      vxb <= vxa;
      vyb <= vya;
      vzb <= vza;
    end
  end

  // stage C: second-level products
  logic signed [AVW-1:0] avx, avy, avz;
  logic signed [XDW-1:0] xdc, ydc, zdc;
  logic signed [WCW-1:0] wcx, wcy, wcz;
  logic signed [NW-1:0]  nc;

  always_ff @(posedge clk) begin
    if (adv) begin
      avx <= ab * vxb;
      avy <= ab * vyb;
      avz <= ab * vzb;
      xdc <= xb * db;
      ydc <= yb * db;
      zdc <= zb * db;
      wcx <= wb * cxb;
      wcy <= wb * cyb;
      wcz <= wb * czb;
      nc  <= nb;
    end
  end

  // stage D: numerators, sign/magnitude, rounding offset
  logic signed [NUMW-1:0] num [3];
  logic        [NUMW-1:0] mag [3];
  logic        [DW-1:0]   dvd_next [3];
  logic        [DW-1:0]   dvd [3];
  logic        [RW-1:0]   den;
  qvr_side_t              side_next, side_d;

  always_comb begin
    num[0] = NUMW'(avx) + ((NUMW'(xdc) + NUMW'(wcx)) <<< 1);
    num[1] = NUMW'(avy) + ((NUMW'(ydc) + NUMW'(wcy)) <<< 1);
    num[2] = NUMW'(avz) + ((NUMW'(zdc) + NUMW'(wcz)) <<< 1);
    for (int k = 0; k < 3; k++) begin
      side_next.neg[k] = num[k][NUMW-1];
      mag[k]           = num[k][NUMW-1] ? NUMW'(-num[k]) : NUMW'(num[k]);
      // (2|n| + N) / 2N rounds half away from zero
      dvd_next[k]      = {1'b0, mag[k], 1'b0} + DW'(unsigned'(nc));
    end
    side_next.zero = (nc == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dvd    <= dvd_next;
      den    <= RW'({nc, 1'b0});
      side_d <= side_next;
    end
  end

  logic [QB-1:0] quo [3];

  for (genvar k = 0; k < 3; k++) begin : g_div
    qvr_div #(
      .DW(DW),
      .RW(RW),
      .QB(QB)
    ) u_div (
      .clk(clk),
      .en (adv),
      .dvd(dvd[k]),
      .den(den),
      .quo(quo[k])
    );
  end

  qvr_side_t side_line [QB];

  always_ff @(posedge clk) begin
    if (adv) begin
      side_line[0] <= side_d;
      for (int i = 1; i < QB; i++) begin
        side_line[i] <= side_line[i-1];
      end
    end
  end

  // output stage: sign, saturation, zero override
  localparam logic [QB-1:0] LIM = QB'(1) << (VW-1);

  logic [VW-1:0] res_next [3];
  logic [2:0]    sat_k;
  qvr_side_t     sd;

  always_comb begin
    sd = side_line[QB-1];
    for (int k = 0; k < 3; k++) begin
      sat_k[k] = 1'b0;
      if (sd.neg[k]) begin
        if (quo[k] > LIM) begin
          sat_k[k]    = 1'b1;
          res_next[k] = {1'b1, {(VW-1){1'b0}}};
        end else begin
          res_next[k] = VW'(~quo[k] + QB'(1));
        end
      end else begin
        if (quo[k] > LIM - QB'(1)) begin
          sat_k[k]    = 1'b1;
          res_next[k] = {1'b0, {(VW-1){1'b1}}};
        end else begin
          res_next[k] = quo[k][VW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sd.zero) begin
        rot_x     <= '0;
        rot_y     <= '0;
        rot_z     <= '0;
        saturated <= 1'b0;
      end else begin
        rot_x     <= res_next[0];
        rot_y     <= res_next[1];
        rot_z     <= res_next[2];
        saturated <= |sat_k;
      end
      zero_quat <= sd.zero;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/qvr_check.sv
// Port-level checker for the rotate core, bound to the top level.
`default_nettype none
`include "quaternion_vector_rotate_core_macros.svh"
module qvr_check #(
  parameter int VEC_BITS = 32
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [VEC_BITS-1:0] rot_x,
  input wire logic [VEC_BITS-1:0] rot_y,
  input wire logic [VEC_BITS-1:0] rot_z,
  input wire logic                saturated,
  input wire logic                zero_quat
);
  logic wait_out;
  logic res_zero;

  assign wait_out = out_valid && !out_ready;
  assign res_zero = ({rot_x, rot_y, rot_z, saturated} == '0);

  `QVR_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid)
  `QVR_ASSERT_NOW(a_stall_blocks_input, clk, rst, wait_out, !in_ready)
  `QVR_ASSERT_NOW(a_zero_result, clk, rst, out_valid && zero_quat, res_zero)
  `QVR_ASSERT_NEXT(a_hold, clk, rst, wait_out, out_valid && $stable({rot_x, rot_y, rot_z}))
endmodule

bind quaternion_vector_rotate_core qvr_check #(.VEC_BITS(VEC_BITS)) u_qvr_check (.*);
`default_nettype wire
